[rtl/pba_pkg.sv]
// shared constants, codes and request types for the page bitmap allocator
`default_nettype none
package pba_pkg;

  localparam int NUM_PAGES  = 1024;
  localparam int PAGE_W     = 10;
  localparam int PAGE_SHIFT = 5;
  localparam int WORD_BITS  = 16;
  localparam int BIT_W      = 4;
  localparam int MAP_WORDS  = NUM_PAGES / WORD_BITS;
  localparam int WORD_W     = 6;
  localparam int LEN_W      = 8;
  localparam int NEED_W     = 9;
  localparam int MAX_RUN    = 255;
  localparam int SIZE_W     = 13;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_GROW  = 2'd2;

  typedef struct packed {
    logic                 rd_en;
    logic [WORD_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } map_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    logic [LEN_W-1:0]  wr_data;
  } len_req_t;

  // last page of a range, held at the top page
  function automatic logic [PAGE_W-1:0] clip_page(input logic [PAGE_W:0] e);
    logic [PAGE_W-1:0] r;
    r = e[PAGE_W] ? {PAGE_W{1'b1}} : e[PAGE_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/pba_map_mem.sv]
// used-page bitmap memory with per-word valid bits cleared at reset
`default_nettype none
module pba_map_mem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pba_pkg::map_req_t             req,
  output logic [pba_pkg::WORD_BITS-1:0]      rdata
);
  import pba_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/pba_len_ram.sv]
// run-length store, one page count per page
`default_nettype none
module pba_len_ram (
  input  wire logic                      clk,
  input  wire pba_pkg::len_req_t         req,
  output logic [pba_pkg::LEN_W-1:0]      rdata
);
  import pba_pkg::*;

  logic [LEN_W-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/pba_ctrl.sv]
// request sequencer: first-fit scan, range mark and check, result register
`default_nettype none
module pba_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [23:0]                  s_tdata,
  input  wire logic [1:0]                   s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [31:0]                       m_tdata,
  output pba_pkg::map_req_t                 map_req,
  input  wire logic [pba_pkg::WORD_BITS-1:0] map_rdata,
  output pba_pkg::len_req_t                 len_req,
  input  wire logic [pba_pkg::LEN_W-1:0]    len_rdata
);
  import pba_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LRD  = 4'd1;
  localparam logic [3:0] ST_DEC  = 4'd2;
  localparam logic [3:0] ST_SCAN = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_WR   = 4'd5;
  localparam logic [3:0] ST_LENW = 4'd6;
  localparam logic [3:0] ST_DONE = 4'd7;

  localparam logic [1:0] OP_CHECK = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] PH_DONE   = 2'd0;
  localparam logic [1:0] PH_CHECK  = 2'd1;
  localparam logic [1:0] PH_SETLEN = 2'd2;

  logic [3:0]        state;
  logic [1:0]        kind_r;
  logic [SIZE_W-1:0] size_r;
  logic [PAGE_W-1:0] rs_r;
  logic [LEN_W-1:0]  len_r;
  logic [NEED_W-1:0] need_r;
  logic [PAGE_W-1:0] walk_first, walk_last, lw_addr;
  logic [WORD_W-1:0] cur_w;
  logic [1:0]        walk_op, phase;
  logic [WORD_W-1:0] scan_w, proc_w;
  logic              issued_all, pend;
  logic [LEN_W-1:0]  cnt;
  logic              res_ok, res_moved;
  logic [PAGE_W-1:0] res_start, res_old;
  logic [LEN_W-1:0]  res_pages;

  logic [NEED_W-1:0] in_need;
  logic [WORD_BITS-1:0] walk_mask, mask_lo, mask_hi;
  logic [BIT_W-1:0]  lo_b, hi_b;
  logic [WORD_W-1:0] first_w, last_w;
  logic [PAGE_W-1:0] grow_first;

  // scan of one map word
  logic              sc_found;
  logic [BIT_W-1:0]  sc_bit;
  logic [LEN_W-1:0]  sc_cnt;
  logic [PAGE_W:0]   sc_start;

  assign in_need = {1'b0, s_tdata[SIZE_W-1:PAGE_SHIFT]} + NEED_W'(1);
  assign first_w = walk_first[PAGE_W-1:BIT_W];
  assign last_w  = walk_last[PAGE_W-1:BIT_W];
  assign lo_b    = (cur_w == first_w) ? walk_first[BIT_W-1:0] : '0;
  assign hi_b    = (cur_w == last_w) ? walk_last[BIT_W-1:0] : '1;
  assign mask_lo = {WORD_BITS{1'b1}} << lo_b;
  assign mask_hi = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_b);
  assign walk_mask = mask_lo & mask_hi;
  // first page after the current run, where an in-place grow starts
  assign grow_first = rs_r + {2'b0, len_rdata};

  always_comb begin
    logic [BIT_W:0]   pos;
    logic [NEED_W:0]  t;
    sc_found = 1'b0;
    sc_bit   = '0;
    sc_cnt   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pos = '0;
      for (int k = 0; k <= b; k++) begin
        if (map_rdata[k]) pos = (BIT_W+1)'(k + 1);
      end
      // free run ending at this bit, carried in from earlier words when unbroken
      if (pos == '0) t = {2'b0, cnt} + (NEED_W+1)'(b + 1);
      else           t = (NEED_W+1)'(b + 1) - {{(NEED_W-BIT_W){1'b0}}, pos};
      if (!sc_found && t >= {1'b0, need_r}) begin
        sc_found = 1'b1;
        sc_bit   = BIT_W'(b);
      end
      if (b == WORD_BITS - 1) begin
        sc_cnt = (t > (NEED_W+1)'(MAX_RUN)) ? LEN_W'(MAX_RUN) : t[LEN_W-1:0];
      end
    end
    sc_start = {1'b0, proc_w, sc_bit} + (PAGE_W+1)'(1) - {2'b0, need_r};
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    map_req = '0;
    len_req = '0;
    unique case (state)
      ST_SCAN: begin
        map_req.rd_en   = !issued_all;
        map_req.rd_addr = scan_w;
      end
      ST_RD: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = cur_w;
      end
      ST_WR: begin
        map_req.wr_en   = (walk_op != OP_CHECK);
        map_req.wr_addr = cur_w;
        map_req.wr_data = (walk_op == OP_SET) ? (map_rdata | walk_mask)
                                              : (map_rdata & ~walk_mask);
      end
      ST_LRD: begin
        len_req.rd_en   = 1'b1;
        len_req.rd_addr = rs_r;
      end
      ST_LENW: begin
        len_req.wr_en   = 1'b1;
        len_req.wr_addr = lw_addr;
        len_req.wr_data = need_r[LEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
    end else begin
      if (state != ST_DONE && m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_r    <= s_tuser;
            size_r    <= s_tdata[SIZE_W-1:0];
            rs_r      <= s_tdata[SIZE_W+PAGE_W-1:SIZE_W];
            need_r    <= in_need;
            res_ok    <= 1'b0;
            res_start <= '0;
            res_pages <= '0;
            res_moved <= 1'b0;
            res_old   <= '0;
            scan_w     <= '0;
            issued_all <= 1'b0;
            pend       <= 1'b0;
            cnt        <= '0;
            if (s_tuser == KIND_ALLOC) begin
              state <= (in_need > NEED_W'(MAX_RUN)) ? ST_DONE : ST_SCAN;
            end else if (s_tuser == KIND_FREE || s_tuser == KIND_GROW) begin
              state <= ST_LRD;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_LRD: state <= ST_DEC;
        ST_DEC: begin
          len_r     <= len_rdata;
          res_start <= rs_r;
          res_pages <= len_rdata;
          if (kind_r == KIND_FREE) begin
            res_ok <= 1'b1;
            if (len_rdata == '0) begin
              state <= ST_DONE;
            end else begin
              walk_first <= rs_r;
              walk_last  <= clip_page({1'b0, rs_r} + {3'b0, len_rdata} - 11'd1);
              cur_w      <= rs_r[PAGE_W-1:BIT_W];
              walk_op    <= OP_CLEAR;
              phase      <= PH_DONE;
              state      <= ST_RD;
            end
          end else if (size_r < SIZE_W'(1 << PAGE_SHIFT) ||
                       need_r <= {1'b0, len_rdata}) begin
            res_ok <= 1'b1;
            state  <= ST_DONE;
          end else if (need_r > NEED_W'(MAX_RUN)) begin
            state <= ST_DONE;
          end else if ({1'b0, rs_r} + {2'b0, need_r} <= (PAGE_W+1)'(NUM_PAGES)) begin
            walk_first <= grow_first;
            walk_last  <= rs_r + {1'b0, need_r} - PAGE_W'(1);
            cur_w      <= grow_first[PAGE_W-1:BIT_W];
            walk_op    <= OP_CHECK;
            phase      <= PH_CHECK;
            state      <= ST_RD;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (pend && sc_found) begin
            res_ok     <= 1'b1;
            res_start  <= sc_start[PAGE_W-1:0];
            res_pages  <= need_r[LEN_W-1:0];
            res_moved  <= (kind_r == KIND_GROW);
            res_old    <= (kind_r == KIND_GROW) ? rs_r : '0;
            lw_addr    <= sc_start[PAGE_W-1:0];
            walk_first <= sc_start[PAGE_W-1:0];
            walk_last  <= sc_start[PAGE_W-1:0] + {1'b0, need_r} - PAGE_W'(1);
            cur_w      <= sc_start[PAGE_W-1:BIT_W];
            walk_op    <= OP_SET;
            phase      <= PH_SETLEN;
            pend       <= 1'b0;
            state      <= ST_RD;
          end else if (pend && proc_w == WORD_W'(MAP_WORDS - 1)) begin
            // no room: allocate reports zeros, grow keeps the old run
            pend  <= 1'b0;
            state <= ST_DONE;
          end else begin
            if (pend) cnt <= sc_cnt;
            if (!issued_all) begin
              proc_w <= scan_w;
              pend   <= 1'b1;
              scan_w <= scan_w + WORD_W'(1);
              if (scan_w == WORD_W'(MAP_WORDS - 1)) issued_all <= 1'b1;
            end else begin
              pend <= 1'b0;
            end
          end
        end
        ST_RD: state <= ST_WR;
        ST_WR: begin
          if (walk_op == OP_CHECK && (map_rdata & walk_mask) != '0) begin
            scan_w     <= '0;
            issued_all <= 1'b0;
            pend       <= 1'b0;
            cnt        <= '0;
            state      <= ST_SCAN;
          end else if (cur_w == last_w) begin
            priority case (phase)
              PH_CHECK: begin
                res_ok    <= 1'b1;
                res_pages <= need_r[LEN_W-1:0];
                lw_addr   <= rs_r;
                walk_op   <= OP_SET;
                cur_w     <= first_w;
                phase     <= PH_SETLEN;
                state     <= ST_RD;
              end
              PH_SETLEN: state <= ST_LENW;
              default:   state <= ST_DONE;
            endcase
          end else begin
            cur_w <= cur_w + WORD_W'(1);
            state <= ST_RD;
          end
        end
        ST_LENW: begin
          if (res_moved && len_r != '0) begin
            walk_first <= rs_r;
            walk_last  <= clip_page({1'b0, rs_r} + {3'b0, len_r} - 11'd1);
            cur_w      <= rs_r[PAGE_W-1:BIT_W];
            walk_op    <= OP_CLEAR;
            phase      <= PH_DONE;
            state      <= ST_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b0, res_old, res_moved, res_pages, res_start, res_ok};
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    map_req.wr_en |-> !map_req.rd_en) else $error("map read and write together");
  a_scan_need: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (need_r != '0 && need_r <= NEED_W'(MAX_RUN)))
    else $error("scan with bad page count");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE)) else $error("request dropped");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !m_tvalid) |=> m_tvalid) else $error("result not loaded");
`endif

endmodule
`default_nettype wire

[rtl/page_bitmap_allocator_top.sv]
// first-fit page allocator, one request at a time and one result per request. The slowest
// request is a grow that fails its in-place check, scans, marks a new run and clears the old
// one. Speed is bounded by the bitmap memory port: the scan reads one 16-page map word per
// cycle over the 64 words, and marking, clearing or checking a range reads and then writes
// each map word touched, up to 17 words for a 255-page run. Free and grow first read the run
// length. The bitmap clears at reset through per-word valid bits, so no clearing pass is
// needed.
`default_nettype none
module page_bitmap_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // size_bytes[12:0], run_start[22:13]
  input  wire logic [1:0]  s_tuser,  // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata   // ok, result_start, result_pages, moved, old_start
);
  import pba_pkg::*;

  map_req_t             map_req;
  len_req_t             len_req;
  logic [WORD_BITS-1:0] map_rdata;
  logic [LEN_W-1:0]     len_rdata;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .map_req   (map_req),
    .map_rdata (map_rdata),
    .len_req   (len_req),
    .len_rdata (len_rdata)
  );

  pba_map_mem u_map (
    .clk   (clk),
    .rst   (rst),
    .req   (map_req),
    .rdata (map_rdata)
  );

  pba_len_ram u_len (
    .clk   (clk),
    .req   (len_req),
    .rdata (len_rdata)
  );

endmodule
`default_nettype wire

[verif/pba_checker.sv]
// request/result checker with its own allocator predictor for the page bitmap allocator
module pba_checker
  import pba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] start;
    logic [LEN_W-1:0]  pages;
    logic              moved;
    logic [PAGE_W-1:0] old;
  } alloc_res_t;

  logic [NUM_PAGES-1:0] page_busy;
  logic [LEN_W-1:0]     run_len [NUM_PAGES];
  alloc_res_t           expected_q[$];

  function automatic int pages_needed(input logic [SIZE_W-1:0] sz);
    return int'(sz >> PAGE_SHIFT) + 1;
  endfunction

  function automatic bit is_busy(input int p);
    if (p >= NUM_PAGES) return 1'b1;
    return page_busy[p];
  endfunction

  function automatic void set_range(input int first, input int n, input bit v);
    for (int i = 0; i < n; i++) begin
      if (first + i >= NUM_PAGES) break;
      page_busy[first + i] = v;
    end
  endfunction

  function automatic bit first_fit(input int need, output int start);
    int cnt;
    cnt = 0;
    start = 0;
    if (need == 0 || need > MAX_RUN) return 1'b0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (page_busy[p]) cnt = 0;
      else begin
        cnt++;
        if (cnt == need) begin
          start = p + 1 - need;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_res_t apply_request(input logic [1:0] kind,
                                               input logic [SIZE_W-1:0] sz,
                                               input logic [PAGE_W-1:0] rs);
    alloc_res_t r;
    int need, st, len;
    bit room;
    r = '0;
    need = pages_needed(sz);
    if (kind == KIND_ALLOC) begin
      if (first_fit(need, st)) begin
        set_range(st, need, 1'b1);
        run_len[st] = LEN_W'(need);
        r = '{1'b1, PAGE_W'(st), LEN_W'(need), 1'b0, '0};
      end
      return r;
    end
    if (kind != KIND_FREE && kind != KIND_GROW) return r;
    len = int'(run_len[rs]);
    if (kind == KIND_FREE) begin
      set_range(rs, len, 1'b0);
      return '{1'b1, rs, LEN_W'(len), 1'b0, '0};
    end
    if (sz < (1 << PAGE_SHIFT) || need <= len) return '{1'b1, rs, LEN_W'(len), 1'b0, '0};
    if (need > MAX_RUN) return '{1'b0, rs, LEN_W'(len), 1'b0, '0};
    room = (int'(rs) + need <= NUM_PAGES);
    for (int i = int'(rs) + len; room && i < int'(rs) + need; i++)
      if (is_busy(i)) room = 1'b0;
    if (room) begin
      set_range(int'(rs) + len, need - len, 1'b1);
      run_len[rs] = LEN_W'(need);
      return '{1'b1, rs, LEN_W'(need), 1'b0, '0};
    end
    // relocation search still sees the old run as taken
    if (!first_fit(need, st)) return '{1'b0, rs, LEN_W'(len), 1'b0, '0};
    set_range(st, need, 1'b1);
    run_len[st] = LEN_W'(need);
    set_range(rs, len, 1'b0);
    return '{1'b1, PAGE_W'(st), LEN_W'(need), 1'b1, rs};
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alloc_res_t want, got;
    if (rst) begin
      page_busy = '0;
      expected_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(apply_request(s_tuser, s_tdata[12:0], s_tdata[22:13]));
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got = '{m_tdata[0], m_tdata[10:1], m_tdata[18:11], m_tdata[19], m_tdata[29:20]};
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("checker: unexpected result %h", m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_tdata[31:30] !== 2'b00) begin
            if (errors < 10)
              $display({"checker: mismatch exp ok=%0d start=%0d pages=%0d moved=%0d ",
                        "old=%0d, got ok=%0d start=%0d pages=%0d moved=%0d old=%0d"},
                       want.ok, want.start, want.pages, want.moved, want.old,
                       got.ok, got.start, got.pages, got.moved, got.old);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

[verif/tb_top.sv]
// top of the page bitmap allocator testbench: clock, reset, request stimulus and verdict
module tb_top;
  import pba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;
  int          errors, pending, results_seen;
  int          send_idle_pct, recv_idle_pct;
  int          cycles;
  int          n_alloc, n_free, n_grow;
  bit          start_known [NUM_PAGES];
  int          start_pool[$];

  page_bitmap_allocator_top dut (.*);

  pba_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: timeout");
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // any successful result names a run start whose length has been written
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready && m_tdata[0] && !start_known[m_tdata[10:1]]) begin
      start_known[m_tdata[10:1]] = 1'b1;
      start_pool.push_back(int'(m_tdata[10:1]));
    end

  task automatic send_request(input logic [1:0] kind, input int sz, input int rs);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {1'b0, PAGE_W'(rs), SIZE_W'(sz)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (kind)
      KIND_ALLOC: n_alloc++;
      KIND_FREE:  n_free++;
      KIND_GROW:  n_grow++;
      default: ;
    endcase
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic random_request();
    int r, sz, rs;
    r  = $urandom_range(99);
    sz = $urandom_range(99) < 80 ? $urandom_range(300) :
         ($urandom_range(99) < 75 ? $urandom_range(2000) : $urandom_range(8159));
    rs = $urandom_range(NUM_PAGES - 1);
    if (r >= 45 && r < 95 && start_pool.size() != 0) begin
      // favour recently learnt starts, they are more likely still live
      if ($urandom_range(1)) rs = start_pool[$urandom_range(start_pool.size() - 1)];
      else rs = start_pool[start_pool.size() - 1 - $urandom_range(start_pool.size() > 8 ?
                                                                   7 : start_pool.size() - 1)];
      send_request(r < 75 ? KIND_FREE : KIND_GROW, sz, rs);
    end else if (r >= 95) begin
      send_request(KIND_NONE, sz, rs);
    end else begin
      send_request(KIND_ALLOC, sz, rs);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cycles = 0;
    send_idle_pct = 30;
    recv_idle_pct = 51;
    n_alloc = 0; n_free = 0; n_grow = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single pages, a two-page run, the largest run
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_ALLOC, 31, 1023);
    send_request(KIND_ALLOC, 32, 0);
    send_request(KIND_ALLOC, 8159, 0);
    send_request(KIND_GROW, 10, 0);        // too small to grow
    send_request(KIND_GROW, 40, 2);        // needs no more pages
    send_request(KIND_GROW, 100, 2);       // blocked in place, relocates
    send_request(KIND_GROW, 150, 259);     // extends in place
    send_request(KIND_FREE, 0, 4);
    send_request(KIND_GROW, 8159, 1);      // large in-place growth
    send_request(KIND_ALLOC, 8159, 0);
    send_request(KIND_ALLOC, 8159, 0);
    send_request(KIND_ALLOC, 8159, 0);     // no room left
    send_request(KIND_GROW, 8159, 0);      // no room, old run kept
    send_request(KIND_NONE, 8159, 1023);
    send_request(KIND_GROW, 5000, 264);    // needs fewer pages than held
    send_request(KIND_FREE, 0, 1);
    send_request(KIND_FREE, 0, 259);
    send_request(KIND_FREE, 0, 264);
    send_request(KIND_GROW, 100, 0);
    // hold off until every result is back
    drain();

    for (int i = 0; i < 320; i++) random_request();
    send_idle_pct = 51;
    recv_idle_pct = 30;
    for (int i = 0; i < 320; i++) random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 310; i++) random_request();

    drain();
    repeat (100) @(posedge clk);
    $display("tb_top: %0d allocate, %0d free, %0d grow requests, %0d results checked",
             n_alloc, n_free, n_grow, results_seen);
    $display("tb_top: %0d distinct run starts seen, idling on both sides then none",
             start_pool.size());
    if (errors == 0 && pending == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule
